@@ hdl/plni_pkg.sv @@
// Shared constants, codes and pipeline types of the lattice neighbour index block.
`default_nettype none
package plni_pkg;
   localparam int MAX_DIMS   = 4;
   localparam int MAX_LENGTH = 256;
   localparam int SITE_W     = 32;
   localparam int DIR_W      = 3;
   localparam int LEN_W      = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;
   localparam int WIDE_W     = SITE_W + 1;
   localparam int PRE_STAGES = 5;
   localparam int DIV_STAGES = SITE_W;
   localparam int NUM_STAGES = PRE_STAGES + DIV_STAGES + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIMENSIONS = 3'd0,
      CSR_LENGTH0    = 3'd1,
      CSR_LENGTH1    = 3'd2,
      CSR_LENGTH2    = 3'd3,
      CSR_LENGTH3    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [SITE_W-1:0]            site;
      logic [DIR_W-1:0]             dir;
      logic [2:0]                   dims;
      logic [MAX_DIMS-1:0][LEN_W-1:0] len;
      logic [17:0]                  p01;
      logic [26:0]                  p012;
      logic [WIDE_W-1:0]            p0123;
      logic                         err;
      logic                         fwd;
      logic [WIDE_W-1:0]            stride;
      logic [LEN_W-1:0]             laxis;
      logic [WIDE_W-1:0]            span;
      logic [WIDE_W-1:0]            rem;
      logic [SITE_W-1:0]            nb;
   } pipe_type;
endpackage
`default_nettype wire

@@ hdl/plni_req_if.sv @@
// Query channel: site and direction with valid/ready.
`default_nettype none
interface plni_req_if;
   logic                        valid;
   logic                        ready;
   logic [plni_pkg::SITE_W-1:0] site;
   logic [plni_pkg::DIR_W-1:0]  direction;
   modport source (output valid, output site, output direction, input ready);
   modport sink   (input valid, input site, input direction, output ready);
endinterface
`default_nettype wire

@@ hdl/plni_rsp_if.sv @@
// Result channel: neighbour site and error flag with valid/ready.
`default_nettype none
interface plni_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [plni_pkg::SITE_W-1:0] neighbour_site;
   logic                        out_of_range;
   modport source (output valid, output neighbour_site, output out_of_range, input ready);
   modport sink   (input valid, input neighbour_site, input out_of_range, output ready);
endinterface
`default_nettype wire

@@ hdl/periodic_lattice_neighbour_index.sv @@
// Pipeline: 38 stages. Throughput: one query per cycle while the result side is ready.
// Depth comes from four multiplier stages (three length products, then stride times
// length), one validity stage, the 32-stage remainder pipeline (one quotient bit per
// stage) and one wrap stage.
// Each stage holds when it is full and the next one is stalled, so bubbles collapse.
// Reset (synchronous, active high) empties the pipeline and restores the
// registers to 2 dimensions of length 16, 16, 1, 1.
`default_nettype none
module periodic_lattice_neighbour_index (
   input  wire                            clock,
   input  wire                            reset,
   plni_req_if.sink                       req_if,
   plni_rsp_if.source                     rsp_if,
   input  wire                            csr_write_en,
   input  wire [plni_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [plni_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import plni_pkg::*;

   // configuration registers
   logic [2:0]                     dims_ff;
   logic [MAX_DIMS-1:0][LEN_W-1:0] len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff   <= 3'd2;
         len_ff[0] <= LEN_W'(16);
         len_ff[1] <= LEN_W'(16);
         len_ff[2] <= LEN_W'(1);
         len_ff[3] <= LEN_W'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DIMENSIONS: dims_ff   <= csr_wdata[2:0];
            CSR_LENGTH0:    len_ff[0] <= csr_wdata;
            CSR_LENGTH1:    len_ff[1] <= csr_wdata;
            CSR_LENGTH2:    len_ff[2] <= csr_wdata;
            CSR_LENGTH3:    len_ff[3] <= csr_wdata;
            default: ;  // drop writes to unknown registers
         endcase
      end
   end

   pipe_type                st_ff [NUM_STAGES];
   pipe_type                st_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]   v_ff;
   logic [NUM_STAGES:0]     rdy;

   // Stage k advances when it is empty or stage k+1 advances.
   always_comb begin
      rdy[NUM_STAGES] = rsp_if.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_if.ready = rdy[0];

   always_comb begin
      pipe_type          p;
      logic [1:0]        axis;
      logic [WIDE_W-1:0] total;
      logic [WIDE_W-1:0] t;
      logic [WIDE_W:0]   sum;
      logic [WIDE_W:0]   n;
      int                bitpos;
      for (int k = 0; k < NUM_STAGES; k++) begin
         p      = (k == 0) ? st_ff[0] : st_ff[k-1];
         axis   = 2'd0;
         total  = '0;
         t      = '0;
         sum    = '0;
         n      = '0;
         bitpos = 0;
         if (k == 0) begin
            // capture the query with saturated copies of the configuration
            p.site = req_if.site;
            p.dir  = req_if.direction;
            p.dims = (dims_ff > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : dims_ff;
            for (int d = 0; d < MAX_DIMS; d++) begin
               p.len[d] = (len_ff[d] > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : len_ff[d];
            end
            p.p01 = 18'(p.len[0]) * 18'(p.len[1]);
         end else if (k == 1) begin
            p.p012 = 27'(p.p01) * 27'(p.len[2]);
         end else if (k == 2) begin
            p.p0123 = WIDE_W'(p.p012) * WIDE_W'(p.len[3]);
         end else if (k == 3) begin
            // site count, validity, and stride of the stepped axis
            case (p.dims)
               3'd0:    total = WIDE_W'(1);
               3'd1:    total = WIDE_W'(p.len[0]);
               3'd2:    total = WIDE_W'(p.p01);
               3'd3:    total = WIDE_W'(p.p012);
               default: total = p.p0123;
            endcase
            p.err = (WIDE_W'(p.site) >= total) || ({1'b0, p.dir} >= {p.dims, 1'b0});
            p.fwd = p.dir < p.dims;
            axis  = p.fwd ? p.dir[1:0] : 2'(p.dir - p.dims);
            case (axis)
               2'd0:    p.stride = WIDE_W'(1);
               2'd1:    p.stride = WIDE_W'(p.len[0]);
               2'd2:    p.stride = WIDE_W'(p.p01);
               default: p.stride = WIDE_W'(p.p012);
            endcase
            p.laxis = p.len[axis];
         end else if (k == 4) begin
            p.span = p.stride * WIDE_W'(p.laxis);
            p.rem  = '0;
         end else if (k < PRE_STAGES + DIV_STAGES) begin
            // one restoring remainder step per stage, high bit first
            bitpos = PRE_STAGES + DIV_STAGES - 1 - k;
            t = {p.rem[SITE_W-1:0], p.site[bitpos]};
            p.rem = (t >= p.span) ? t - p.span : t;
         end else begin
            // wrap test on the coordinate offset inside one span
            if (p.fwd) begin
               sum = {1'b0, p.rem} + {1'b0, p.stride};
               if (sum >= {1'b0, p.span}) begin
                  n = {1'b0, WIDE_W'(p.site)} + {1'b0, p.stride} - {1'b0, p.span};
               end else begin
                  n = {1'b0, WIDE_W'(p.site)} + {1'b0, p.stride};
               end
            end else begin
               if (p.rem < p.stride) begin
                  n = {1'b0, WIDE_W'(p.site)} + {1'b0, p.span} - {1'b0, p.stride};
               end else begin
                  n = {1'b0, WIDE_W'(p.site)} - {1'b0, p.stride};
               end
            end
            p.nb = p.err ? '0 : n[SITE_W-1:0];
         end
         st_in[k] = p;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= (k == 0) ? req_if.valid : v_ff[k-1];
            end
         end
      end
   end

   assign rsp_if.valid          = v_ff[NUM_STAGES-1];
   assign rsp_if.neighbour_site = st_ff[NUM_STAGES-1].nb;
   assign rsp_if.out_of_range   = st_ff[NUM_STAGES-1].err;
endmodule
`default_nettype wire

@@ tb/periodic_lattice_neighbour_index_test.sv @@
// Self-checking testbench for the periodic lattice neighbour index block.
`default_nettype none
module periodic_lattice_neighbour_index_test;
   timeunit 1ns;
   timeprecision 1ps;
   import plni_pkg::*;

   // Register indexes 5..7 are not mapped; a write there must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   // Cycles to let the pipeline settle before touching the registers.
   localparam int SETTLE_CYCLES = 60;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [SITE_W-1:0] nb;
      logic              oor;
   } neighbour_type;

   typedef struct {
      logic [SITE_W-1:0] site;
      logic [DIR_W-1:0]  dir;
      bit                known;
      neighbour_type     want;
   } query_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   plni_req_if req_ch ();
   plni_rsp_if rsp_ch ();

   periodic_lattice_neighbour_index dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_ch),
      .rsp_if       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Our own copy of the lattice registers.
   logic [2:0]       lat_dims;
   logic [LEN_W-1:0] lat_len [MAX_DIMS];

   neighbour_type expected_neighbours [$];
   neighbour_type known_answers [$];
   int            mismatches = 0;
   idle_mode_type idle_mode = IDLE_NONE;
   bit            long_hold_req = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5ms;
      $display("periodic_lattice_neighbour_index: mismatch");
      $finish;
   end

   function automatic int unsigned active_dims();
      return (lat_dims > MAX_DIMS) ? MAX_DIMS : int'(lat_dims);
   endfunction

   function automatic longint unsigned active_len(int unsigned d);
      longint unsigned l = 64'(lat_len[d]);
      return (l > MAX_LENGTH) ? MAX_LENGTH : l;
   endfunction

   // Product of the lengths of dimensions below d.
   function automatic longint unsigned stride_below(int unsigned d);
      longint unsigned s = 1;
      for (int unsigned k = 0; k < d; k++) s *= active_len(k);
      return s;
   endfunction

   function automatic neighbour_type step_neighbour(logic [SITE_W-1:0] site,
                                                    logic [DIR_W-1:0] dir);
      int unsigned     d = active_dims();
      longint unsigned total = stride_below(d);
      longint unsigned st, span, n, s64;
      int unsigned     axis;
      neighbour_type   r;
      s64 = 64'(site);
      if (s64 >= total || dir >= 2 * d) begin
         r.nb = '0;
         r.oor = 1'b1;
         return r;
      end
      axis = (dir < d) ? dir : dir - d;
      st = stride_below(axis);
      span = st * active_len(axis);
      if (dir < d) begin
         // Step forward; pull back by a full span when the step wrapped.
         n = s64 + st;
         if (n % span < st) n -= span;
      end else begin
         if (s64 % span < st) n = s64 + span - st;
         else n = s64 - st;
      end
      r.nb = n[SITE_W-1:0];
      r.oor = 1'b0;
      return r;
   endfunction

   // Record the expectation of every query transfer; registers are stable then.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         if (known_answers.size() > 0) expected_neighbours.push_back(known_answers.pop_front());
         else expected_neighbours.push_back(step_neighbour(req_ch.site, req_ch.direction));
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      neighbour_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_neighbours.size() == 0) begin
            $error("unexpected result: neighbour_site %0h out_of_range %0b",
                   rsp_ch.neighbour_site, rsp_ch.out_of_range);
            mismatches++;
         end else begin
            want = expected_neighbours.pop_front();
            if (rsp_ch.neighbour_site !== want.nb) begin
               $error("neighbour_site: expected %0h, actual %0h", want.nb, rsp_ch.neighbour_site);
               mismatches++;
            end
            if (rsp_ch.out_of_range !== want.oor) begin
               $error("out_of_range: expected %0b, actual %0b", want.oor, rsp_ch.out_of_range);
               mismatches++;
            end
         end
      end
   end

   // Receiver: stall at random per mode; a toggle of long_hold_req holds off
   // for a long stretch so the pipeline fills and backs up onto the input.
   always @(negedge clock) begin
      static bit hold_seen = 1'b0;
      static int hold_left = 0;
      if (long_hold_req != hold_seen) begin
         hold_seen = long_hold_req;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready = 1'b0;
      end else if (idle_mode == IDLE_RECEIVER) begin
         rsp_ch.ready = ($urandom_range(99) >= 46);
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_ch.ready = ($urandom_range(99) >= 11);
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      // Track the register in our copy; unmapped indexes are dropped.
      if (idx == CSR_DIMENSIONS) lat_dims = value[2:0];
      else if (idx <= CSR_LENGTH3) lat_len[idx - 1] = value;
   endtask

   task automatic set_lattice(logic [2:0] dims, logic [LEN_W-1:0] l0, logic [LEN_W-1:0] l1,
                              logic [LEN_W-1:0] l2, logic [LEN_W-1:0] l3);
      write_reg(CSR_DIMENSIONS, CSR_DATA_W'(dims));
      write_reg(CSR_LENGTH0, l0);
      write_reg(CSR_LENGTH1, l1);
      write_reg(CSR_LENGTH2, l2);
      write_reg(CSR_LENGTH3, l3);
   endtask

   // Offer one query and hold it until the transfer.
   task automatic send_query(logic [SITE_W-1:0] site, logic [DIR_W-1:0] dir);
      int gap_pct = (idle_mode == IDLE_SENDER) ? 46 : (idle_mode == IDLE_BOTH) ? 11 : 0;
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.site = site;
      req_ch.direction = dir;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid, then wait for every outstanding result and let the block settle.
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      wait (expected_neighbours.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Pick a site: mostly inside the lattice, with edges and raw noise.
   function automatic logic [SITE_W-1:0] pick_site();
      longint unsigned total = stride_below(active_dims());
      int unsigned     r = $urandom_range(9);
      longint unsigned w = {$urandom, $urandom};
      if (r == 0 || total == 0) return SITE_W'($urandom);
      if (r == 1) return SITE_W'(total - 1);
      if (r == 2) return (total > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : SITE_W'(total);
      if (r == 3) return '0;
      return SITE_W'(w % total);
   endfunction

   function automatic logic [DIR_W-1:0] pick_dir();
      int unsigned d = active_dims();
      if (d == 0 || $urandom_range(9) == 0) return DIR_W'($urandom_range(7));
      return DIR_W'($urandom_range(2 * d - 1));
   endfunction

   task automatic run_random(int count);
      repeat (count) send_query(pick_site(), pick_dir());
   endtask

   query_row_type directed [$];

   initial begin
      logic [LEN_W-1:0] lens [MAX_DIMS];
      req_ch.valid = 1'b0;
      req_ch.site = '0;
      req_ch.direction = '0;
      rsp_ch.ready = 1'b1;
      lat_dims = 3'd2;
      lat_len = '{9'd16, 9'd16, 9'd1, 9'd1};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset lattice is 16 x 16: the corner and wrap cases read off directly.
      directed = '{
         '{32'd0,          3'd0, 1, '{32'd1,   1'b0}},
         '{32'd0,          3'd1, 1, '{32'd16,  1'b0}},
         '{32'd0,          3'd2, 1, '{32'd15,  1'b0}},
         '{32'd0,          3'd3, 1, '{32'd240, 1'b0}},
         '{32'd15,         3'd0, 1, '{32'd0,   1'b0}},
         '{32'd255,        3'd0, 1, '{32'd240, 1'b0}},
         '{32'd255,        3'd1, 1, '{32'd15,  1'b0}},
         '{32'd240,        3'd3, 1, '{32'd224, 1'b0}},
         '{32'd256,        3'd0, 1, '{32'd0,   1'b1}},
         '{32'd5,          3'd4, 1, '{32'd0,   1'b1}},
         '{32'd5,          3'd7, 1, '{32'd0,   1'b1}},
         '{32'hFFFF_FFFF,  3'd1, 1, '{32'd0,   1'b1}},
         '{32'd37,         3'd1, 0, '{32'd0,   1'b0}},
         '{32'd100,        3'd2, 0, '{32'd0,   1'b0}},
         '{32'd170,        3'd3, 0, '{32'd0,   1'b0}}
      };
      foreach (directed[i]) begin
         if (directed[i].known) known_answers.push_back(directed[i].want);
         else known_answers.push_back(step_neighbour(directed[i].site, directed[i].dir));
         send_query(directed[i].site, directed[i].dir);
      end
      drain();

      // Fixed settings covering the extremes, then random ones.
      for (int phase = 0; phase < 14; phase++) begin
         idle_mode = idle_mode_type'(phase % 4);
         case (phase)
            0: set_lattice(3'd4, 9'd256, 9'd256, 9'd256, 9'd256);   // full 32-bit site range
            1: set_lattice(3'd1, 9'd256, 9'd3, 9'd3, 9'd3);
            2: set_lattice(3'd0, 9'd4, 9'd4, 9'd4, 9'd4);           // no valid direction
            3: set_lattice(3'd7, 9'd5, 9'd3, 9'd2, 9'd7);           // dims saturate
            4: set_lattice(3'd3, 9'd6, 9'd0, 9'd5, 9'd9);           // zero length in use
            5: set_lattice(3'd4, 9'd1, 9'd1, 9'd1, 9'd1);           // every step returns site
            6: set_lattice(3'd2, 9'd511, 9'd300, 9'd0, 9'd0);       // oversized, unused zeros
            7: begin
               set_lattice(3'd4, 9'd2, 9'd1, 9'd3, 9'd256);
               write_reg(CSR_UNMAPPED, 9'h1FF);
            end
            default: begin
               foreach (lens[k]) begin
                  case ($urandom_range(9))
                     0: lens[k] = 9'd0;
                     1: lens[k] = 9'd256;
                     2: lens[k] = LEN_W'($urandom_range(257, 511));
                     3: lens[k] = 9'd1;
                     default: lens[k] = LEN_W'($urandom_range(2, 20));
                  endcase
               end
               set_lattice(3'($urandom_range(9) == 0 ? $urandom_range(7) : $urandom_range(1, 4)),
                           lens[0], lens[1], lens[2], lens[3]);
            end
         endcase
         if (phase == 1) begin
            // Hold off the receiver while queries keep coming; the input must stall.
            long_hold_req = ~long_hold_req;
            run_random(80);
         end
         run_random(100);
         drain();
      end

      if (mismatches == 0 && expected_neighbours.size() == 0) begin
         $display("periodic_lattice_neighbour_index: match");
      end else begin
         $display("periodic_lattice_neighbour_index: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/plni_pkg.sv
hdl/plni_req_if.sv
hdl/plni_rsp_if.sv
hdl/periodic_lattice_neighbour_index.sv
tb/periodic_lattice_neighbour_index_test.sv
